// ===== rtl/core/tlpm_pkg.sv =====
// Shared types and constants for the two-level page map writer.
// No dependencies; tlpm_front, tlpm_back and the top level refer to it by scoped names.
package tlpm_pkg;

    localparam int POOL_TABLES_DEF = 16;
    localparam int TABLE_ENTRIES   = 1024;
    localparam int DIR_ENTRIES     = 1024;
    localparam int IDX_W           = 10;
    localparam int QUEUE_DEPTH     = 2;

    // present, writable, user
    localparam logic [11:0] PDE_FLAGS   = 12'h007;
    localparam logic [31:0] PTE_PRESENT = 32'h0000_0001;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BAD_VA = 2'd1,
        ST_BAD_PA = 2'd2,
        ST_NO_MEM = 2'd3
    } t_status;

    typedef enum logic {
        REG_FREE_BASE = 1'b0,
        REG_FREE_END  = 1'b1
    } t_reg_sel;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RD,
        S_CHK,
        S_CLR,
        S_WR,
        S_RB,
        S_OUT
    } t_back_state;

    typedef struct packed {
        logic [31:0] virt_addr;
        logic [31:0] phys_addr;
        logic [11:0] entry_flags;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic        table_allocated;
        logic [31:0] dir_entry;
        logic [31:0] table_entry;
    } t_res;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] dir_idx;
        logic [IDX_W-1:0] tbl_idx;
        logic [31:0]      pte;
    } t_job;

endpackage

// ===== rtl/core/tlpm_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module tlpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/tlpm_fifo.sv =====
// Small register queue used between the front and back parts and for results.
// No dependencies.
module tlpm_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_cnt == CNT_W'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_rdata   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_do_push) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_do_pop) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// ===== rtl/core/tlpm_front.sv =====
// Front part: takes request words, checks alignment, splits the indexes
// and builds the table entry. Depends on tlpm_pkg.
module tlpm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  tlpm_pkg::t_req i_req,
    input  logic          i_init,
    output logic          o_q_push,
    output tlpm_pkg::t_job o_q_job,
    input  logic          i_q_full
);

    logic           r_vld, n_vld;
    tlpm_pkg::t_job r_job, n_job;
    tlpm_pkg::t_job w_job;
    logic           w_take;
    logic           w_drain;

    always_comb begin
        w_job.dir_idx = i_req.virt_addr[31:22];
        w_job.tbl_idx = i_req.virt_addr[21:12];
        w_job.pte     = i_req.phys_addr | {20'b0, i_req.entry_flags} | tlpm_pkg::PTE_PRESENT;
        priority if (i_req.virt_addr[11:0] != 12'b0) begin
            w_job.status = tlpm_pkg::ST_BAD_VA;
        end else if (i_req.phys_addr[11:0] != 12'b0) begin
            w_job.status = tlpm_pkg::ST_BAD_PA;
        end else begin
            w_job.status = tlpm_pkg::ST_OK;
        end
    end

    assign w_drain  = r_vld && !i_q_full;
    assign o_full   = i_init || (r_vld && i_q_full);
    assign w_take   = i_push && !o_full;
    assign o_q_push = r_vld;
    assign o_q_job  = r_job;

    always_comb begin
        n_vld = w_take || (r_vld && !w_drain);
        n_job = w_take ? w_job : r_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

endmodule

// ===== rtl/core/tlpm_back.sv =====
// Back part: directory lookup, table allocation and clearing, entry write.
// Depends on tlpm_pkg and tlpm_ram (directory and table pool).
module tlpm_back #(
    parameter int POOL_TABLES = tlpm_pkg::POOL_TABLES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [31:0]    i_free_base,
    input  logic [31:0]    i_free_end,
    input  logic           i_q_empty,
    input  tlpm_pkg::t_job i_q_job,
    output logic           o_q_pop,
    output logic           o_r_push,
    output tlpm_pkg::t_res o_res,
    input  logic           i_r_full,
    output logic           o_init
);

    localparam int IDX_W   = tlpm_pkg::IDX_W;
    localparam int SLOT_W  = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
    localparam int CNT_W   = $clog2(POOL_TABLES + 1);
    localparam int POOL_AW = $clog2(POOL_TABLES * tlpm_pkg::TABLE_ENTRIES);
    localparam int DIR_W   = 32 + SLOT_W;

    tlpm_pkg::t_back_state r_state, n_state;
    tlpm_pkg::t_job        r_job, n_job;
    tlpm_pkg::t_status     r_status, n_status;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic [CNT_W-1:0]      r_used, n_used;
    logic [IDX_W-1:0]      r_clr, n_clr;
    logic                  r_alloc, n_alloc;
    logic                  r_ok, n_ok;
    logic [31:0]           r_pde, n_pde;

    logic                     dir_we;
    logic [IDX_W-1:0]         dir_addr;
    logic [DIR_W-1:0]         dir_wdata;
    logic [DIR_W-1:0]         dir_rdata;
    logic                     pool_we;
    logic [SLOT_W+IDX_W-1:0]  pool_full_addr;
    logic [31:0]              pool_wdata;
    logic [31:0]              pool_rdata;

    logic                     w_present;
    logic                     w_oom;
    logic                     w_clr_last;
    logic [20:0]              w_end_pg;
    logic [19:0]              w_tbl_pg;
    logic [31:0]              w_new_pde;
    logic [SLOT_W-1:0]        w_new_slot;

    tlpm_ram #(
        .WIDTH (DIR_W),
        .DEPTH (tlpm_pkg::DIR_ENTRIES)
    ) u_dir (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_addr  (dir_addr),
        .i_wdata (dir_wdata),
        .o_rdata (dir_rdata)
    );

    tlpm_ram #(
        .WIDTH (32),
        .DEPTH (POOL_TABLES * tlpm_pkg::TABLE_ENTRIES)
    ) u_pool (
        .i_clk   (i_clk),
        .i_we    (pool_we),
        .i_addr  (pool_full_addr[POOL_AW-1:0]),
        .i_wdata (pool_wdata),
        .o_rdata (pool_rdata)
    );

    // Allocation check: the new table ends at base + (used + 1) pages.
    // free_end is below 4 GiB, so passing it also rules out wrap past 32 bits.
    assign w_present  = dir_rdata[0];
    assign w_end_pg   = {1'b0, i_free_base[31:12]} + 21'(r_used) + 21'd1;
    assign w_oom      = (r_used >= CNT_W'(POOL_TABLES))
                     || (w_end_pg > {1'b0, i_free_end[31:12]});
    assign w_tbl_pg   = i_free_base[31:12] + 20'(r_used);
    assign w_new_pde  = {w_tbl_pg, tlpm_pkg::PDE_FLAGS};
    assign w_new_slot = r_used[SLOT_W-1:0];
    assign w_clr_last = (r_clr == {IDX_W{1'b1}});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tlpm_pkg::S_INIT: begin
                if (w_clr_last) n_state = tlpm_pkg::S_IDLE;
            end
            tlpm_pkg::S_IDLE: begin
                if (!i_q_empty) n_state = tlpm_pkg::S_RD;
            end
            tlpm_pkg::S_RD: begin
                n_state = tlpm_pkg::S_CHK;
            end
            tlpm_pkg::S_CHK: begin
                priority if (r_job.status != tlpm_pkg::ST_OK) begin
                    n_state = tlpm_pkg::S_OUT;
                end else if (w_present) begin
                    n_state = tlpm_pkg::S_WR;
                end else if (w_oom) begin
                    n_state = tlpm_pkg::S_OUT;
                end else begin
                    n_state = tlpm_pkg::S_CLR;
                end
            end
            tlpm_pkg::S_CLR: begin
                if (w_clr_last) n_state = tlpm_pkg::S_WR;
            end
            tlpm_pkg::S_WR: begin
                n_state = tlpm_pkg::S_RB;
            end
            tlpm_pkg::S_RB: begin
                n_state = tlpm_pkg::S_OUT;
            end
            tlpm_pkg::S_OUT: begin
                if (!i_r_full) n_state = tlpm_pkg::S_IDLE;
            end
            default: n_state = tlpm_pkg::S_INIT;
        endcase
    end

    // outputs and datapath
    always_comb begin
        dir_we         = 1'b0;
        dir_addr       = r_job.dir_idx;
        dir_wdata      = {w_new_slot, w_new_pde};
        pool_we        = 1'b0;
        pool_full_addr = {r_slot, r_job.tbl_idx};
        pool_wdata     = r_job.pte;
        o_q_pop        = 1'b0;
        o_r_push       = 1'b0;
        n_job          = r_job;
        n_status       = r_status;
        n_slot         = r_slot;
        n_used         = r_used;
        n_clr          = r_clr;
        n_alloc        = r_alloc;
        n_ok           = r_ok;
        n_pde          = r_pde;
        unique case (r_state)
            tlpm_pkg::S_INIT: begin
                dir_we    = 1'b1;
                dir_addr  = r_clr;
                dir_wdata = '0;
                n_clr     = r_clr + 1'b1;
            end
            tlpm_pkg::S_IDLE: begin
                o_q_pop = !i_q_empty;
                n_job   = i_q_job;
                n_alloc = 1'b0;
            end
            tlpm_pkg::S_RD: begin
            end
            tlpm_pkg::S_CHK: begin
                n_status = r_job.status;
                n_pde    = dir_rdata[31:0];
                n_ok     = 1'b0;
                priority if (r_job.status != tlpm_pkg::ST_OK) begin
                    n_ok = 1'b0;
                end else if (w_present) begin
                    n_slot = dir_rdata[32 +: SLOT_W];
                    n_ok   = 1'b1;
                end else if (w_oom) begin
                    n_status = tlpm_pkg::ST_NO_MEM;
                end else begin
                    dir_we  = 1'b1;
                    n_slot  = w_new_slot;
                    n_pde   = w_new_pde;
                    n_used  = r_used + 1'b1;
                    n_alloc = 1'b1;
                    n_clr   = '0;
                    n_ok    = 1'b1;
                end
            end
            tlpm_pkg::S_CLR: begin
                pool_we        = 1'b1;
                pool_full_addr = {r_slot, r_clr};
                pool_wdata     = '0;
                n_clr          = r_clr + 1'b1;
            end
            tlpm_pkg::S_WR: begin
                pool_we = 1'b1;
            end
            tlpm_pkg::S_RB: begin
            end
            tlpm_pkg::S_OUT: begin
                o_r_push = !i_r_full;
            end
            default: begin
            end
        endcase
    end

    assign o_init                = (r_state == tlpm_pkg::S_INIT);
    assign o_res.status          = r_status;
    assign o_res.table_allocated = r_alloc;
    assign o_res.dir_entry       = r_pde;
    // read back the entry just written; zero on any error
    assign o_res.table_entry     = r_ok ? pool_rdata : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlpm_pkg::S_INIT;
            r_used  <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job    <= n_job;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_alloc  <= n_alloc;
        r_ok     <= n_ok;
        r_pde    <= n_pde;
    end

`ifndef ASSERT_OFF
    a_alloc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_r_push && o_res.table_allocated |-> o_res.status == tlpm_pkg::ST_OK)
        else $error("table allocated on a failed request");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(POOL_TABLES))
        else $error("table count beyond pool size");

    a_pte_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_r_push && o_res.status == tlpm_pkg::ST_OK |-> o_res.table_entry[0])
        else $error("written table entry not present");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_state == tlpm_pkg::S_RD)
        else $error("job taken outside idle");

    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tlpm_pkg::S_CHK && n_alloc && !r_alloc |=> r_used == $past(r_used) + 1'b1)
        else $error("allocation did not advance table count");
`endif

endmodule

// ===== rtl/core/two_level_page_map_writer.sv =====
// Top level of the two-level page map writer: config registers, queues,
// front and back parts. Depends on tlpm_pkg, tlpm_fifo, tlpm_front, tlpm_back.
//
//  channel   handshake                         word
//  request   push / full                       i_req  (virt_addr, phys_addr, entry_flags)
//  result    pop / empty                       o_res  (status, table_allocated, dir_entry,
//                                                      table_entry)
//  config    psel, penable, pwrite, pready     paddr 0: free_base, 4: free_end
//
//  After reset the directory is cleared entry by entry; full stays high until then.
//  A request passes IDLE, RD and CHK in the back part, then goes on to OUT on an alignment
//  or pool error, through WR and RB when the directory entry is present, and through CLR,
//  WR and RB when a table is allocated; CLR clears it through the pool's single port.
//  The front stage and two-word queues take requests until they fill, while the back
//  part works and while a result waits to be popped.
module two_level_page_map_writer #(
    parameter int POOL_TABLES = tlpm_pkg::POOL_TABLES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  tlpm_pkg::t_req i_req,
    input  logic           pop,
    output logic           empty,
    output tlpm_pkg::t_res o_res,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int JOB_W = $bits(tlpm_pkg::t_job);
    localparam int RES_W = $bits(tlpm_pkg::t_res);

    logic [31:0]        r_free_base, n_free_base;
    logic [31:0]        r_free_end, n_free_end;
    tlpm_pkg::t_reg_sel w_sel;
    logic               w_wr;

    logic               init;
    logic               jq_push, jq_full, jq_pop, jq_empty;
    tlpm_pkg::t_job     jq_wjob;
    logic [JOB_W-1:0]   jq_rdata;
    logic               rq_push, rq_full;
    tlpm_pkg::t_res     rq_wres;
    logic [RES_W-1:0]   rq_rdata;

    assign pready = 1'b1;
    assign w_sel  = tlpm_pkg::t_reg_sel'(paddr[2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_free_base = r_free_base;
        n_free_end  = r_free_end;
        unique case (w_sel)
            tlpm_pkg::REG_FREE_BASE: begin
                prdata = r_free_base;
                if (w_wr) n_free_base = pwdata;
            end
            tlpm_pkg::REG_FREE_END: begin
                prdata = r_free_end;
                if (w_wr) n_free_end = pwdata;
            end
            default: prdata = 32'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_base <= '0;
            r_free_end  <= '0;
        end else begin
            r_free_base <= n_free_base;
            r_free_end  <= n_free_end;
        end
    end

    tlpm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_req    (i_req),
        .i_init   (init),
        .o_q_push (jq_push),
        .o_q_job  (jq_wjob),
        .i_q_full (jq_full)
    );

    tlpm_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (tlpm_pkg::QUEUE_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (jq_push),
        .i_wdata (jq_wjob),
        .o_full  (jq_full),
        .i_pop   (jq_pop),
        .o_rdata (jq_rdata),
        .o_empty (jq_empty)
    );

    tlpm_back #(
        .POOL_TABLES (POOL_TABLES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_free_base (r_free_base),
        .i_free_end  (r_free_end),
        .i_q_empty   (jq_empty),
        .i_q_job     (tlpm_pkg::t_job'(jq_rdata)),
        .o_q_pop     (jq_pop),
        .o_r_push    (rq_push),
        .o_res       (rq_wres),
        .i_r_full    (rq_full),
        .o_init      (init)
    );

    tlpm_fifo #(
        .WIDTH (RES_W),
        .DEPTH (tlpm_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_wdata (rq_wres),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_rdata (rq_rdata),
        .o_empty (empty)
    );

    assign o_res = tlpm_pkg::t_res'(rq_rdata);

endmodule
